### hw/rtl/format_markup_tokenizer_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the format markup tokenizer
// Concurrent checks clocked on clk_i, disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef FORMAT_MARKUP_TOKENIZER_UNIT_ASSERT_SVH
`define FORMAT_MARKUP_TOKENIZER_UNIT_ASSERT_SVH

// Property that holds at every clock edge out of reset.
`define FMTU_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// Antecedent implies the consequent in the following cycle.
`define FMTU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/fmtu_pkg.sv
// ---------------------------------------------------------------------------
// Format markup tokenizer package
// Payload types, token kinds, error codes and sizing constants.
// ---------------------------------------------------------------------------
package fmtu_pkg;

  // Spec brace counter width
  localparam int unsigned NEST_BITS   = 8;
  // Results a single byte can produce
  localparam int unsigned MAX_RESULTS = 3;
  // Result queue
  localparam int unsigned FIFO_DEPTH  = 8;
  localparam int unsigned PTR_W       = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W       = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;
  localparam logic [7:0] CH_LBRACK  = 8'h5B;
  localparam logic [7:0] CH_RBRACK  = 8'h5D;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_BANG    = 8'h21;

  localparam logic [2:0] KIND_LIT   = 3'd0;
  localparam logic [2:0] KIND_OPEN  = 3'd1;
  localparam logic [2:0] KIND_NAME  = 3'd2;
  localparam logic [2:0] KIND_CONV  = 3'd3;
  localparam logic [2:0] KIND_SPEC  = 3'd4;
  localparam logic [2:0] KIND_CLOSE = 3'd5;
  localparam logic [2:0] KIND_ERR   = 3'd6;
  localparam logic [2:0] KIND_END   = 3'd7;

  localparam logic [3:0] ERR_NONE         = 4'd0;
  localparam logic [3:0] ERR_LONE_CLOSE   = 4'd1;
  localparam logic [3:0] ERR_LONE_OPEN    = 4'd2;
  localparam logic [3:0] ERR_BRACE_NAME   = 4'd3;
  localparam logic [3:0] ERR_NO_CLOSE     = 4'd4;
  localparam logic [3:0] ERR_NO_CONV      = 4'd5;
  localparam logic [3:0] ERR_NO_COLON     = 4'd6;
  localparam logic [3:0] ERR_UNMATCHED    = 4'd7;
  localparam logic [3:0] ERR_NEST_OVFL    = 4'd8;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       is_final;
  } in_item_t;

  typedef struct packed {
    logic [2:0] token_kind;
    logic [7:0] token_byte;
    logic [3:0] error_code;
    logic       string_done;
  } out_item_t;

endpackage

### hw/rtl/format_markup_tokenizer_unit.sv
// ---------------------------------------------------------------------------
// Format markup tokenizer
// Streams a UTF-8 format string byte by byte into tagged markup tokens.
// ---------------------------------------------------------------------------
// One byte is taken per cycle while in_stall_o is low. The parse state is
// updated in the same cycle and the byte's zero to three tokens are written
// into an eight-entry result queue; the output port drains one token per
// cycle while out_stall_i is low. The byte rate therefore equals one byte
// per cycle while bytes yield at most one token on average, and is set by
// the single-token output port otherwise. Input stalls whenever the queue
// has fewer than three free entries; results are registered in the queue.
module format_markup_tokenizer_unit
  import fmtu_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  `include "format_markup_tokenizer_unit_assert.svh"

  typedef enum logic [3:0] {
    MODE_LIT,
    MODE_OPEN,
    MODE_CLOSE,
    MODE_NAME,
    MODE_BRACKET,
    MODE_CONV1,
    MODE_CONVN,
    MODE_CONVEND,
    MODE_SPEC,
    MODE_DROP
  } mode_e;

  mode_e                mode_q, mode_d;
  logic [NEST_BITS-1:0] nest_q, nest_d;
  logic [1:0]           rem_q, rem_d;

  out_item_t            fifo_q [FIFO_DEPTH];
  logic [PTR_W-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]     count_q;

  out_item_t            res [MAX_RESULTS];
  logic [1:0]           n_res;
  logic                 in_fire, out_fire;

  assign in_stall_o  = count_q > CNT_W'(FIFO_DEPTH - MAX_RESULTS);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign out_valid_o = count_q != '0;
  assign out_fire    = out_valid_o && !out_stall_i;
  assign out_data_o  = fifo_q[rd_ptr_q];

  // Parse step for the byte at the input
  always_comb begin
    logic [7:0]           c;
    logic                 fin;
    logic [3:0]           err;
    logic                 do_name;
    logic                 drop;
    logic [NEST_BITS-1:0] nest_dec;

    c        = in_data_i.char_byte;
    fin      = in_data_i.is_final;
    err      = ERR_NONE;
    do_name  = 1'b0;
    drop     = 1'b0;
    mode_d   = mode_q;
    nest_d   = nest_q;
    rem_d    = rem_q;
    n_res    = 2'd0;
    nest_dec = (nest_q != '0) ? nest_q - 1'b1 : '0;
    for (int k = 0; k < MAX_RESULTS; k++) begin
      res[k] = '0;
    end

    case (mode_q)
      MODE_LIT: begin
        if (c == CH_LBRACE) begin
          mode_d = MODE_OPEN;
        end else if (c == CH_RBRACE) begin
          mode_d = MODE_CLOSE;
        end else begin
          res[n_res] = '{KIND_LIT, c, ERR_NONE, 1'b0};
          n_res = n_res + 2'd1;
        end
      end
      MODE_OPEN: begin
        if (c == CH_LBRACE) begin
          res[n_res] = '{KIND_LIT, c, ERR_NONE, 1'b0};
          n_res  = n_res + 2'd1;
          mode_d = MODE_LIT;
        end else begin
          res[n_res] = '{KIND_OPEN, 8'h00, ERR_NONE, 1'b0};
          n_res   = n_res + 2'd1;
          do_name = 1'b1;
        end
      end
      MODE_CLOSE: begin
        if (c == CH_RBRACE) begin
          res[n_res] = '{KIND_LIT, c, ERR_NONE, 1'b0};
          n_res  = n_res + 2'd1;
          mode_d = MODE_LIT;
        end else begin
          err = ERR_LONE_CLOSE;
        end
      end
      MODE_NAME: begin
        do_name = 1'b1;
      end
      MODE_BRACKET: begin
        res[n_res] = '{KIND_NAME, c, ERR_NONE, 1'b0};
        n_res = n_res + 2'd1;
        if (c == CH_RBRACK) begin
          mode_d = MODE_NAME;
        end
      end
      MODE_CONV1: begin
        res[n_res] = '{KIND_CONV, c, ERR_NONE, 1'b0};
        n_res = n_res + 2'd1;
        if (c >= 8'hC0 && c <= 8'hDF) begin
          rem_d = 2'd1;
        end else if (c >= 8'hE0 && c <= 8'hEF) begin
          rem_d = 2'd2;
        end else if (c >= 8'hF0 && c <= 8'hF7) begin
          rem_d = 2'd3;
        end else begin
          rem_d = 2'd0;
        end
        mode_d = (rem_d != 2'd0) ? MODE_CONVN : MODE_CONVEND;
      end
      MODE_CONVN: begin
        res[n_res] = '{KIND_CONV, c, ERR_NONE, 1'b0};
        n_res = n_res + 2'd1;
        rem_d = rem_q - 2'd1;
        if (rem_d == 2'd0) begin
          mode_d = MODE_CONVEND;
        end
      end
      MODE_CONVEND: begin
        if (c == CH_RBRACE) begin
          res[n_res] = '{KIND_CLOSE, 8'h00, ERR_NONE, 1'b0};
          n_res  = n_res + 2'd1;
          mode_d = MODE_LIT;
        end else if (c == CH_COLON) begin
          nest_d = NEST_BITS'(1);
          mode_d = MODE_SPEC;
        end else begin
          err = ERR_NO_COLON;
        end
      end
      MODE_SPEC: begin
        if (c == CH_LBRACE) begin
          if (&nest_q) begin
            err = ERR_NEST_OVFL;
          end else begin
            nest_d = nest_q + 1'b1;
            res[n_res] = '{KIND_SPEC, c, ERR_NONE, 1'b0};
            n_res = n_res + 2'd1;
          end
        end else if (c == CH_RBRACE) begin
          nest_d = nest_dec;
          if (nest_dec == '0) begin
            res[n_res] = '{KIND_CLOSE, 8'h00, ERR_NONE, 1'b0};
            n_res  = n_res + 2'd1;
            mode_d = MODE_LIT;
          end else begin
            res[n_res] = '{KIND_SPEC, c, ERR_NONE, 1'b0};
            n_res = n_res + 2'd1;
          end
        end else begin
          res[n_res] = '{KIND_SPEC, c, ERR_NONE, 1'b0};
          n_res = n_res + 2'd1;
        end
      end
      default: begin
        drop = 1'b1;
      end
    endcase

    // Name byte outside brackets, also the first byte after a field open
    if (do_name) begin
      mode_d = MODE_NAME;
      if (c == CH_LBRACE) begin
        err = ERR_BRACE_NAME;
      end else if (c == CH_LBRACK) begin
        res[n_res] = '{KIND_NAME, c, ERR_NONE, 1'b0};
        n_res  = n_res + 2'd1;
        mode_d = MODE_BRACKET;
      end else if (c == CH_RBRACE) begin
        res[n_res] = '{KIND_CLOSE, 8'h00, ERR_NONE, 1'b0};
        n_res  = n_res + 2'd1;
        mode_d = MODE_LIT;
      end else if (c == CH_COLON) begin
        nest_d = NEST_BITS'(1);
        mode_d = MODE_SPEC;
      end else if (c == CH_BANG) begin
        mode_d = MODE_CONV1;
      end else begin
        res[n_res] = '{KIND_NAME, c, ERR_NONE, 1'b0};
        n_res = n_res + 2'd1;
      end
    end

    if (drop) begin
      if (fin) begin
        mode_d = MODE_LIT;
        nest_d = '0;
        rem_d  = 2'd0;
      end
    end else if (err != ERR_NONE) begin
      res[n_res] = '{KIND_ERR, 8'h00, err, 1'b1};
      n_res = n_res + 2'd1;
      if (fin) begin
        mode_d = MODE_LIT;
        nest_d = '0;
        rem_d  = 2'd0;
      end else begin
        mode_d = MODE_DROP;
      end
    end else if (fin) begin
      case (mode_d)
        MODE_LIT:     res[n_res] = '{KIND_END, 8'h00, ERR_NONE, 1'b1};
        MODE_OPEN:    res[n_res] = '{KIND_ERR, 8'h00, ERR_LONE_OPEN, 1'b1};
        MODE_CLOSE:   res[n_res] = '{KIND_ERR, 8'h00, ERR_LONE_CLOSE, 1'b1};
        MODE_NAME,
        MODE_BRACKET: res[n_res] = '{KIND_ERR, 8'h00, ERR_NO_CLOSE, 1'b1};
        MODE_CONV1:   res[n_res] = '{KIND_ERR, 8'h00, ERR_NO_CONV, 1'b1};
        default:      res[n_res] = '{KIND_ERR, 8'h00, ERR_UNMATCHED, 1'b1};
      endcase
      n_res  = n_res + 2'd1;
      mode_d = MODE_LIT;
      nest_d = '0;
      rem_d  = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_LIT;
      nest_q   <= '0;
      rem_q    <= 2'd0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (in_fire) begin
        mode_q   <= mode_d;
        nest_q   <= nest_d;
        rem_q    <= rem_d;
        wr_ptr_q <= wr_ptr_q + PTR_W'(n_res);
      end
      if (out_fire) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_q + (in_fire ? CNT_W'(n_res) : '0) - CNT_W'(out_fire);
    end
  end

  // Result queue storage, up to three entries written per transaction
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      for (int k = 0; k < MAX_RESULTS; k++) begin
        if (k < int'(n_res)) begin
          fifo_q[wr_ptr_q + PTR_W'(k)] <= res[k];
        end
      end
    end
  end

  `FMTU_ASSERT_ALWAYS(a_count_bound, count_q <= CNT_W'(FIFO_DEPTH), "result queue overrun")
  `FMTU_ASSERT_ALWAYS(a_convn_rem, (mode_q != MODE_CONVN) || (rem_q != 2'd0), "conversion count lost")
  `FMTU_ASSERT_NEXT(a_final_reset, in_fire && in_data_i.is_final, (mode_q == MODE_LIT) && (nest_q == '0) && (rem_q == 2'd0), "state not cleared after final byte")

endmodule
